/* hw/rtl/fire_effect_field_update_defines.svh */
// Assertion macros shared by the heat field RTL.
`ifndef FIRE_EFFECT_FIELD_UPDATE_DEFINES_SVH
`define FIRE_EFFECT_FIELD_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that a condition implies another in the same cycle.
`define FFU_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("heat field assertion failed");

// Check that a condition implies another in the next cycle.
`define FFU_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("heat field assertion failed");

`else

`define FFU_ASSERT_IMP(label, clk, rst, cond, prop)
`define FFU_ASSERT_NXT(label, clk, rst, cond, prop)

`endif

`endif

/* hw/rtl/ffu_pkg.sv */
// Types and constants for the fire heat field update block.
`timescale 1ns / 1ps

package ffu_pkg;

  localparam int DEF_FIELD_WIDTH  = 256;
  localparam int DEF_FIELD_HEIGHT = 128;

  localparam int CELL_W = 8;
  localparam int SUM_W  = 10;
  localparam int RECIP_W = 16;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic [CELL_W-1:0] HEAT_MAX  = 8'd255;
  localparam logic [CELL_W-1:0] HEAT_COLD = 8'd0;

  // sum * 32 / 129 == (sum * 65028) >> 18, exact for every sum of four cells
  localparam logic [RECIP_W-1:0] HEAT_RECIP = 16'd65028;
  localparam int HEAT_SHIFT = 18;

  typedef enum logic [1:0] {
    CMD_SEED    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ROW,
    ST_DRAIN
  } state_t;

  // One returned pair of reads headed into the heat pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic past_end;
    logic bottom;
  } ffu_tap_t;

  // Write-back request from the heat pipe
  typedef struct packed {
    logic              valid;
    logic              busy;
    logic [CELL_W-1:0] heat;
  } ffu_wr_t;

endpackage

/* hw/rtl/ffu_heat_pipe.sv */
// Sliding neighbor window, heat sum and scaled divide for one field row.
`timescale 1ns / 1ps

module ffu_heat_pipe import ffu_pkg::*; #(
  parameter int FIELD_WIDTH = DEF_FIELD_WIDTH,
  localparam int COL_W = $clog2(FIELD_WIDTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  ffu_tap_t          tap,
  input  logic [COL_W-1:0]  tap_col,
  input  logic [CELL_W-1:0] above_data,
  input  logic [CELL_W-1:0] below_data,
  output ffu_wr_t           wr,
  output logic [COL_W-1:0]  wr_col
);

  logic [CELL_W-1:0] win_l;
  logic [CELL_W-1:0] win_m;
  logic [CELL_W-1:0] b_prev;
  logic [CELL_W-1:0] right;
  logic [CELL_W-1:0] low_term;
  logic [SUM_W-1:0]  sum_next;

  logic              vs;
  logic [SUM_W-1:0]  sum_r;
  logic [COL_W-1:0]  col_s;
  logic              vp;
  logic [PROD_W-1:0] prod_r;
  logic [COL_W-1:0]  col_p;

  // Zero the right neighbor past the last column, pin the low term on the lowest row updated
  always_comb begin
    right    = tap.past_end ? HEAT_COLD : above_data;
    low_term = tap.bottom ? HEAT_MAX : b_prev;
    sum_next = SUM_W'(win_l) + SUM_W'(win_m) + SUM_W'(right) + SUM_W'(low_term);
  end

  // Advance the window over the row below
  always_ff @(posedge clk) begin
    if (tap.valid) begin
      if (tap.first) begin
        win_l <= HEAT_COLD;
        win_m <= above_data;
      end else begin
        win_l <= win_m;
        win_m <= right;
      end
      b_prev <= below_data;
    end
  end

  // Sum stage, then multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
      vp <= 1'b0;
    end else begin
      vs <= tap.valid && !tap.first;
      vp <= vs;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_next;
    col_s  <= tap_col;
    prod_r <= PROD_W'(sum_r) * PROD_W'(HEAT_RECIP);
    col_p  <= col_s;
  end

  // Hand the finished cell back for write-back
  always_comb begin
    wr.valid = vp;
    wr.busy  = vs | vp;
    wr.heat  = prod_r[HEAT_SHIFT +: CELL_W];
    wr_col   = col_p;
  end

endmodule

/* hw/rtl/fire_effect_field_update.sv */
// Top level of the fire heat field: cell memory, command sequencer and result register.
`timescale 1ns / 1ps
`include "fire_effect_field_update_defines.svh"

// Fire heat field. The cells live in one synchronous memory with one write
// port and two read ports, addressed as {row, column} with each part rounded
// up to a power of two. After reset a clearing pass writes zero to every
// entry, one per cycle; no item is taken until it ends. Seed and unused
// commands load their result as they are taken, a read goes through the read
// state for one memory read. An advance walks the rows from the top, one cell
// per cycle, reading the row below and the row two below on the two read ports
// and writing the new cell through the sum and multiply pipe; each row drains
// that pipe before the next row starts reading it. One item is in work at a
// time; its result waits in an output register, and the next item is taken as
// soon as that register is free or being emptied.
module fire_effect_field_update import ffu_pkg::*; #(
  parameter int FIELD_WIDTH  = DEF_FIELD_WIDTH,
  parameter int FIELD_HEIGHT = DEF_FIELD_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        command,
  input  logic [7:0]        column,
  input  logic [6:0]        row,
  input  logic              noise_hot,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CELL_W-1:0] cell_value
);

  localparam int COL_W  = $clog2(FIELD_WIDTH);
  localparam int ROW_W  = $clog2(FIELD_HEIGHT);
  localparam int XW     = $clog2(FIELD_WIDTH + 1);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  state_t state;
  state_t state_next;

  logic [CELL_W-1:0] heat_mem [DEPTH];
  logic [CELL_W-1:0] rd_a;
  logic [CELL_W-1:0] rd_b;

  logic [ADDR_W-1:0] clr_addr;
  logic [XW-1:0]     x_rd;
  logic [ROW_W-1:0]  y_cnt;
  logic              v1;
  logic [XW-1:0]     x1;
  logic              rd_ok;

  logic              take;
  logic              col_in;
  logic              row_in;
  logic              clr_done;
  logic              x_last;
  logic              y_last;
  logic              row_done;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic              out_load;
  logic [CELL_W-1:0] out_data;

  ffu_tap_t          tap;
  logic [COL_W-1:0]  tap_col;
  ffu_wr_t           wr;
  logic [COL_W-1:0]  wr_col;

  // Decode the beat and the sequencer conditions
  always_comb begin
    take     = item_valid && !item_stall;
    col_in   = 32'(column) < 32'(FIELD_WIDTH);
    row_in   = 32'(row) < 32'(FIELD_HEIGHT);
    clr_done = &clr_addr;
    x_last   = x_rd == XW'(FIELD_WIDTH);
    y_last   = y_cnt == ROW_W'(FIELD_HEIGHT - 2);
    row_done = !v1 && !wr.busy;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take && command == CMD_ADVANCE) begin
          state_next = ST_ROW;
        end else if (take && command == CMD_READ) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_ROW: begin
        if (x_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (row_done) state_next = y_last ? ST_IDLE : ST_ROW;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Handshake, memory write select and result load
  always_comb begin
    item_stall = !(state == ST_IDLE && (!result_valid || !result_stall));
    mem_we     = 1'b0;
    mem_waddr  = {y_cnt, wr_col};
    mem_wdata  = wr.heat;
    out_load   = 1'b0;
    out_data   = HEAT_COLD;
    priority if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = HEAT_COLD;
    end else if (state == ST_IDLE) begin
      if (take && command == CMD_SEED && col_in) begin
        mem_we    = 1'b1;
        mem_waddr = {ROW_W'(FIELD_HEIGHT - 1), COL_W'(column)};
        mem_wdata = noise_hot ? HEAT_MAX : HEAT_COLD;
      end
      out_load = take && command != CMD_ADVANCE && command != CMD_READ;
    end else if (state == ST_READ) begin
      out_load = 1'b1;
      out_data = rd_ok ? rd_a : HEAT_COLD;
    end else begin
      mem_we   = wr.valid;
      out_load = state == ST_DRAIN && row_done && y_last;
    end
  end

  // Read addresses: the requested cell, or the two rows below the one in work
  always_comb begin
    if (state == ST_IDLE) begin
      raddr_a = {ROW_W'(row), COL_W'(column)};
    end else begin
      raddr_a = {ROW_W'(y_cnt + ROW_W'(1)), COL_W'(x_rd)};
    end
    raddr_b = {ROW_W'(y_cnt + ROW_W'(2)), COL_W'(x_rd)};
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (mem_we) heat_mem[mem_waddr] <= mem_wdata;
    rd_a <= heat_mem[raddr_a];
    rd_b <= heat_mem[raddr_b];
  end

  // Sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      x_rd     <= '0;
      y_cnt    <= '0;
      v1       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (state == ST_ROW) begin
        x_rd <= x_rd + XW'(1);
      end else begin
        x_rd <= '0;
      end
      if (state == ST_IDLE) begin
        y_cnt <= '0;
      end else if (state == ST_DRAIN && row_done && !y_last) begin
        y_cnt <= y_cnt + ROW_W'(1);
      end
      v1 <= state == ST_ROW;
    end
  end

  // Track the column of the returned reads and the range check of a read
  always_ff @(posedge clk) begin
    x1 <= x_rd;
    if (take) rd_ok <= col_in && row_in;
  end

  // Describe the returned pair for the heat pipe
  always_comb begin
    tap.valid    = v1;
    tap.first    = x1 == '0;
    tap.past_end = x1 == XW'(FIELD_WIDTH);
    tap.bottom   = y_last;
    tap_col      = COL_W'(x1 - XW'(1));
  end

  ffu_heat_pipe #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_heat_pipe (
    .clk        (clk),
    .rst        (rst),
    .tap        (tap),
    .tap_col    (tap_col),
    .above_data (rd_a),
    .below_data (rd_b),
    .wr         (wr),
    .wr_col     (wr_col)
  );

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) cell_value <= out_data;
  end

  `FFU_ASSERT_IMP(a_wr_in_advance, clk, rst, wr.valid, (state == ST_ROW || state == ST_DRAIN))
  `FFU_ASSERT_NXT(a_read_result, clk, rst, state == ST_READ, result_valid)
  `FFU_ASSERT_NXT(a_advance_result, clk, rst, state == ST_DRAIN && state_next == ST_IDLE, result_valid)
  `FFU_ASSERT_IMP(a_clear_quiet, clk, rst, state == ST_CLEAR, !result_valid && !wr.busy)

endmodule

/* tb/heat_field_checker.sv */
// Checker for the fire heat field: tracks the cells, predicts each read and compares results.
`timescale 1ns / 1ps

module heat_field_checker import ffu_pkg::*; #(
  parameter int FIELD_WIDTH  = DEF_FIELD_WIDTH,
  parameter int FIELD_HEIGHT = DEF_FIELD_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic [1:0]        command,
  input  logic [7:0]        column,
  input  logic [6:0]        row,
  input  logic              noise_hot,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [CELL_W-1:0] cell_value,
  output int                failures,
  output int                pending
);

  localparam int HEAT_GAIN    = 32;
  localparam int HEAT_DIVISOR = 129;
  localparam int REPORT_LIMIT = 10;

  logic [CELL_W-1:0] heat [FIELD_HEIGHT][FIELD_WIDTH];
  logic [CELL_W-1:0] cell_values_due [$];
  int                bad_beats = 0;

  assign failures = bad_beats;

  // Recompute rows top-down in place; rows below the current one are still last frame's.
  function automatic void burn_frame();
    for (int y = 0; y + 1 < FIELD_HEIGHT; y++) begin
      for (int x = 0; x < FIELD_WIDTH; x++) begin
        int total;
        total = heat[y+1][x];
        if (x > 0) total += heat[y+1][x-1];
        if (x + 1 < FIELD_WIDTH) total += heat[y+1][x+1];
        if (y + 2 >= FIELD_HEIGHT) begin
          total += HEAT_MAX;
        end else begin
          total += heat[y+2][x];
        end
        heat[y][x] = CELL_W'(total * HEAT_GAIN / HEAT_DIVISOR);
      end
    end
  endfunction

  // Apply one accepted beat to the field and return the cell value it should produce.
  function automatic logic [CELL_W-1:0] apply_beat(input logic [1:0] op, input logic [7:0] col,
                                                   input logic [6:0] rw, input logic hot);
    logic [CELL_W-1:0] value;
    value = HEAT_COLD;
    case (op)
      CMD_SEED: begin
        // seed always lands on the bottom row
        if (col < FIELD_WIDTH) heat[FIELD_HEIGHT-1][col] = hot ? HEAT_MAX : HEAT_COLD;
      end
      CMD_ADVANCE: begin
        burn_frame();
      end
      CMD_READ: begin
        if (col < FIELD_WIDTH && rw < FIELD_HEIGHT) value = heat[rw][col];
      end
      default: begin
      end
    endcase
    return value;
  endfunction

  // Watch both channels: match results against the oldest prediction, then queue new ones.
  always @(posedge clk) begin : watch
    logic [CELL_W-1:0] due;
    if (rst) begin
      foreach (heat[y, x]) heat[y][x] = HEAT_COLD;
      cell_values_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (cell_values_due.size() == 0) begin
          if (bad_beats < REPORT_LIMIT)
            $display("unexpected result beat: cell_value %0d", cell_value);
          bad_beats++;
        end else begin
          due = cell_values_due.pop_front();
          if (cell_value !== due) begin
            if (bad_beats < REPORT_LIMIT)
              $display("cell_value mismatch: expected %0d, got %0d", due, cell_value);
            bad_beats++;
          end
        end
      end
      if (item_valid && !item_stall)
        cell_values_due.push_back(apply_beat(command, column, row, noise_hot));
    end
    pending <= cell_values_due.size();
  end

endmodule

/* tb/testbench.sv */
// Testbench top for the fire heat field: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import ffu_pkg::*;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned RUN_LIMIT      = 2_000_000;
  localparam int          PHASE_BEATS    = 25;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          PRESSURE_BEATS = 12;
  localparam int          SETTLE_CYCLES  = 40;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic [1:0]        command      = CMD_SEED;
  logic [7:0]        column       = 8'd0;
  logic [6:0]        row          = 7'd0;
  logic              noise_hot    = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [CELL_W-1:0] cell_value;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int advances_left = 10;
  int failures;
  int pending;

  always #5 clk = ~clk;

  fire_effect_field_update dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .column       (column),
    .row          (row),
    .noise_hot    (noise_hot),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_value   (cell_value)
  );

  heat_field_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .column       (column),
    .row          (row),
    .noise_hot    (noise_hot),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_value   (cell_value),
    .failures     (failures),
    .pending      (pending)
  );

  // Stall results at random, or hold off for a long stretch when one is requested.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one beat after an optional idle gap; return at the edge that takes it.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] col,
                           input logic [6:0] rw, input logic hot);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    command    <= op;
    column     <= col;
    row        <= rw;
    noise_hot  <= hot;
    do @(posedge clk); while (item_stall);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly seeds and reads near the burning rows, a few frames and some unused commands.
  task automatic random_beat();
    int         pick;
    logic [6:0] rw;
    pick = $urandom_range(99);
    rw = ($urandom_range(9) < 7) ? 7'($urandom_range(127, 112)) : 7'($urandom_range(127));
    if (advances_left > 0 && pick < 8) begin
      advances_left--;
      send_beat(CMD_ADVANCE, 8'($urandom), 7'($urandom), 1'($urandom));
    end else if (pick < 50) begin
      send_beat(CMD_SEED, 8'($urandom), 7'($urandom), $urandom_range(3) != 0);
    end else if (pick < 94) begin
      send_beat(CMD_READ, 8'($urandom), rw, 1'($urandom));
    end else begin
      send_beat(CMD_UNUSED, 8'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  // End the run if it hangs.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // cleared field at both corners
    send_beat(CMD_READ, 8'd0, 7'd0, 1'b0);
    send_beat(CMD_READ, 8'd255, 7'd127, 1'b1);
    // seed both edges and the middle; the row field must not matter
    send_beat(CMD_SEED, 8'd0, 7'd0, 1'b1);
    send_beat(CMD_SEED, 8'd255, 7'd127, 1'b1);
    send_beat(CMD_SEED, 8'd128, 7'd64, 1'b1);
    // hot then cold on the same cell
    send_beat(CMD_SEED, 8'd5, 7'd0, 1'b1);
    send_beat(CMD_SEED, 8'd5, 7'd0, 1'b0);
    send_beat(CMD_UNUSED, 8'd255, 7'd127, 1'b1);
    send_beat(CMD_READ, 8'd0, 7'd127, 1'b0);
    send_beat(CMD_READ, 8'd5, 7'd127, 1'b0);
    send_beat(CMD_READ, 8'd255, 7'd127, 1'b0);
    // one frame: check edge columns and the row fed by the constant lower term
    send_beat(CMD_ADVANCE, 8'd0, 7'd0, 1'b0);
    send_beat(CMD_READ, 8'd0, 7'd126, 1'b0);
    send_beat(CMD_READ, 8'd1, 7'd126, 1'b0);
    send_beat(CMD_READ, 8'd127, 7'd126, 1'b0);
    send_beat(CMD_READ, 8'd255, 7'd126, 1'b0);
    send_beat(CMD_READ, 8'd0, 7'd0, 1'b0);
    // second frame: heat climbs one more row
    send_beat(CMD_ADVANCE, 8'd255, 7'd127, 1'b1);
    send_beat(CMD_READ, 8'd0, 7'd125, 1'b0);
    send_beat(CMD_READ, 8'd128, 7'd125, 1'b0);
    send_beat(CMD_READ, 8'd254, 7'd126, 1'b0);
    send_beat(CMD_UNUSED, 8'd0, 7'd0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      if (phase == 0) begin
        // hold off results while beats keep coming, to back up the block
        hold_requests++;
        repeat (PRESSURE_BEATS) begin
          if ($urandom_range(1) != 0) begin
            send_beat(CMD_READ, 8'($urandom), 7'($urandom_range(127, 120)), 1'($urandom));
          end else begin
            send_beat(CMD_SEED, 8'($urandom), 7'($urandom), 1'($urandom));
          end
        end
      end
      repeat (PHASE_BEATS) random_beat();
      if (phase == 2) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
